### rtl/core/rmp_pkg.sv
package rmp_pkg;

  localparam int MaxWidthDef = 4096;
  localparam int BlockUnit   = 5;
  localparam int LevelMax    = 10;
  localparam int QueueDepth  = 4;

  localparam int LevelW   = 4;
  localparam int ImgWidthW = 13;
  localparam int CoordW   = 12;
  localparam int PhaseW   = 6;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEVEL  = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_X_LOW  = 3'd2,
    REG_X_HIGH = 3'd3,
    REG_Y_LOW  = 3'd4,
    REG_Y_HIGH = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // block edge in pixels, level clamped to 1..10
  function automatic logic [PhaseW-1:0] block_edge(input logic [LevelW-1:0] level);
    logic [LevelW-1:0] lvl;
    logic [PhaseW-1:0] l6;
    lvl = level;
    if (lvl < LevelW'(1)) lvl = LevelW'(1);
    if (lvl > LevelW'(LevelMax)) lvl = LevelW'(LevelMax);
    l6 = PhaseW'(lvl);
    return (l6 << 2) + l6;
  endfunction

endpackage

### rtl/core/rmp_fifo.sv
module rmp_fifo import rmp_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [Width-1:0]             data_i,
  input  logic                         pop_i,
  output logic [Width-1:0]             data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(Depth+1)-1:0]   count_o
);

  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth+1);

  logic [Width-1:0] slot_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + AddrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + AddrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) count_d = count_q + CntW'(1);
    else if (!push_i && pop_i) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

### rtl/core/rmp_front.sv
module rmp_front import rmp_pkg::*; #(
  parameter int MaxWidth = MaxWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [CfgIdxW-1:0]            cfg_index_i,
  input  logic [CfgDataW-1:0]           cfg_data_i,
  input  logic                          accept_i,
  input  pixel_t                        pixel_i,
  input  logic                          frame_start_i,
  output pixel_t                        pixel_o,
  output logic                          inside_o,
  output logic                          wr_o,
  output logic [$clog2(MaxWidth)-1:0]   col_o,
  output logic [$clog2(MaxWidth)-1:0]   anchor_o,
  output logic                          last_o
);

  localparam int ColW = $clog2(MaxWidth);
  localparam int WidW = (ColW + 1 > ImgWidthW) ? ColW + 1 : ImgWidthW;
  localparam int XW   = (ColW > CoordW) ? ColW : CoordW;

  logic [LevelW-1:0]    level_q;
  logic [ImgWidthW-1:0] img_width_q;
  logic [CoordW-1:0]    x_low_q, x_high_q, y_low_q, y_high_q;

  logic [ColW-1:0]   col_q, col_d, col;
  logic [CoordW-1:0] row_q, row_d, row;
  logic [PhaseW-1:0] cph_q, cph_d, cph, rph_q, rph_d, rph;
  logic [PhaseW-1:0] edge_len;
  logic [WidW-1:0]   width_raw, width;
  logic              last;

  function automatic logic [PhaseW-1:0] next_phase(input logic [PhaseW-1:0] p,
                                                   input logic [PhaseW-1:0] e);
    return ({1'b0, p} + (PhaseW+1)'(1) >= {1'b0, e}) ? '0 : p + PhaseW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= LevelW'(1);
      img_width_q <= ImgWidthW'(640);
      x_low_q     <= '0;
      x_high_q    <= '1;
      y_low_q     <= '0;
      y_high_q    <= '1;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_LEVEL:  level_q     <= cfg_data_i[LevelW-1:0];
        REG_WIDTH:  img_width_q <= cfg_data_i[ImgWidthW-1:0];
        REG_X_LOW:  x_low_q     <= cfg_data_i[CoordW-1:0];
        REG_X_HIGH: x_high_q    <= cfg_data_i[CoordW-1:0];
        REG_Y_LOW:  y_low_q     <= cfg_data_i[CoordW-1:0];
        REG_Y_HIGH: y_high_q    <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // frame start clears position before this pixel is classified
  always_comb begin
    col = frame_start_i ? '0 : col_q;
    row = frame_start_i ? '0 : row_q;
    cph = frame_start_i ? '0 : cph_q;
    rph = frame_start_i ? '0 : rph_q;

    edge_len  = block_edge(level_q);
    width_raw = WidW'(img_width_q);
    if (width_raw == '0) width = WidW'(1);
    else if (width_raw > WidW'(MaxWidth)) width = WidW'(MaxWidth);
    else width = width_raw;

    last = (WidW'(col) + WidW'(1) >= width);

    inside_o = (XW'(col) >= XW'(x_low_q)) && (XW'(col) <= XW'(x_high_q))
            && (row >= y_low_q) && (row <= y_high_q);
    anchor_o = (ColW'(cph) <= col) ? col - ColW'(cph) : '0;
    wr_o     = (rph == '0);
    col_o    = col;
    last_o   = last;
    pixel_o  = pixel_i;

    if (last) begin
      col_d = '0;
      cph_d = '0;
      row_d = row + CoordW'(1);
      rph_d = next_phase(rph, edge_len);
    end else begin
      col_d = col + ColW'(1);
      cph_d = next_phase(cph, edge_len);
      row_d = row;
      rph_d = rph;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

endmodule

### rtl/core/rmp_back.sv
module rmp_back import rmp_pkg::*; #(
  parameter int MaxWidth = MaxWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  input  pixel_t                        pixel_i,
  input  logic                          inside_i,
  input  logic                          wr_i,
  input  logic [$clog2(MaxWidth)-1:0]   col_i,
  input  logic [$clog2(MaxWidth)-1:0]   anchor_i,
  input  logic                          last_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output pixel_t                        pixel_o,
  output logic                          row_end_o
);

  localparam int CntW = $clog2(QueueDepth+1);
  localparam int OutW = $bits(pixel_t) + 1;

  pixel_t anchor_mem [MaxWidth];
  pixel_t rd_q;
  pixel_t s1_pixel_q, result;
  logic   s1_valid_q, s1_inside_q, s1_fwd_q, s1_last_q;
  logic   issue, out_full, out_pop;
  logic [CntW-1:0] out_cnt;
  logic [OutW-1:0] out_word;

  // credit: words in the output queue plus the one in the read stage
  assign issue   = !q_empty_i && ((CntW+1)'(out_cnt) + (CntW+1)'(s1_valid_q)
                                  < (CntW+1)'(QueueDepth));
  assign q_pop_o = issue;

  always_ff @(posedge clk_i) begin
    if (issue && wr_i) anchor_mem[col_i] <= pixel_i;
    if (issue) rd_q <= anchor_mem[anchor_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= issue;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_pixel_q  <= pixel_i;
      s1_inside_q <= inside_i;
      // anchor written by this same word: read sees old data, forward it
      s1_fwd_q    <= wr_i && (anchor_i == col_i);
      s1_last_q   <= last_i;
    end
  end

  always_comb begin
    if (s1_inside_q && !s1_fwd_q) result = rd_q;
    else                          result = s1_pixel_q;
  end

  assign out_pop = pop_i && !empty_o;

  rmp_fifo #(
    .Width (OutW),
    .Depth (QueueDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .data_i  ({result, s1_last_q}),
    .pop_i   (out_pop),
    .data_o  (out_word),
    .full_o  (out_full),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

  assign pixel_o   = out_word[OutW-1:1];
  assign row_end_o = out_word[0] && !out_full | out_word[0];

endmodule

### rtl/core/region_mosaic_pixelation_core.sv
// Mosaic pixelation of a BGR raster stream, one pixel word per clock sustained
// while the result side is popped. Pixels inside the inclusive rectangle take
// the color of their block's top-left anchor (block edge 5 x level); all others
// pass unchanged. Anchor rows are held in a MAX_WIDTH x 24 line store with one
// write and one read port, which sets the one-word-per-cycle rate. From push to
// the result side a word passes the input queue, the line store read stage and
// the output queue, in that order. Both queues are four words deep. The line
// store is not cleared after reset; each frame writes an entry before reading it.
// Configuration is taken at any time on a ready-always port but must only be
// changed while no pixel is in flight.
module region_mosaic_pixelation_core import rmp_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          blue_in_i,
  input  logic [7:0]          green_in_i,
  input  logic [7:0]          red_in_i,
  input  logic                frame_start_i,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          blue_out_o,
  output logic [7:0]          green_out_o,
  output logic [7:0]          red_out_o,
  output logic                row_end_o
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int ItemW = $bits(pixel_t) + 3 + 2 * ColW;

  pixel_t            in_pixel, item_pixel, q_pixel, out_pixel;
  logic              in_accept;
  logic              item_inside, item_wr, item_last;
  logic [ColW-1:0]   item_col, item_anchor;
  logic              q_inside, q_wr, q_last, q_empty, q_pop;
  logic [ColW-1:0]   q_col, q_anchor;
  logic [ItemW-1:0]  q_word;
  logic [$clog2(QueueDepth+1)-1:0] q_cnt;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = push && !full;
  assign in_pixel    = '{red: red_in_i, green: green_in_i, blue: blue_in_i};

  rmp_front #(
    .MaxWidth (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (in_accept),
    .pixel_i       (in_pixel),
    .frame_start_i (frame_start_i),
    .pixel_o       (item_pixel),
    .inside_o      (item_inside),
    .wr_o          (item_wr),
    .col_o         (item_col),
    .anchor_o      (item_anchor),
    .last_o        (item_last)
  );

  rmp_fifo #(
    .Width (ItemW),
    .Depth (QueueDepth)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  ({item_pixel, item_inside, item_wr, item_col, item_anchor, item_last}),
    .pop_i   (q_pop),
    .data_o  (q_word),
    .full_o  (full),
    .empty_o (q_empty),
    .count_o (q_cnt)
  );

  assign {q_pixel, q_inside, q_wr, q_col, q_anchor, q_last} = q_word;

  rmp_back #(
    .MaxWidth (MAX_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pixel_i   (q_pixel),
    .inside_i  (q_inside),
    .wr_i      (q_wr),
    .col_i     (q_col),
    .anchor_i  (q_anchor),
    .last_i    (q_last),
    .pop_i     (pop),
    .empty_o   (empty),
    .pixel_o   (out_pixel),
    .row_end_o (row_end_o)
  );

  assign blue_out_o  = out_pixel.blue;
  assign green_out_o = out_pixel.green;
  assign red_out_o   = out_pixel.red;

  // anchor never lies right of its own column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> item_anchor <= item_col)
    else $error("anchor column beyond pixel column");

  // a frame start word is classified at column zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && frame_start_i |-> item_col == '0)
    else $error("frame start not at column zero");

  // a queued word is visible to the back end on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !q_empty)
    else $error("accepted word lost from item queue");

  // back end only takes words that exist
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty && q_cnt != '0)
    else $error("item queue underflow");

endmodule
